@@ rtl/ldpc_layered_min_sum_node_assert.svh @@
// assertion macros for the rtl of the check-node unit
`ifndef LDPC_LAYERED_MIN_SUM_NODE_ASSERT_SVH
`define LDPC_LAYERED_MIN_SUM_NODE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LDPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LDPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LDPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LDPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/ldpc_pkg.sv @@
`timescale 1ns / 1ps

package ldpc_pkg;

    // sizing
    localparam int LDPC_MAX_LIFT  = 384;
    localparam int OUT_FIFO_DEPTH = 8;
    localparam int CFG_ADDR_W     = 4;
    localparam int APB_DATA_W     = 32;

    // register reset values
    localparam logic [8:0] LIFT_SIZE_RESET = 9'd384;
    localparam logic [7:0] SCALE_RESET     = 8'd102;
    localparam logic [6:0] LLR_MAX_RESET   = 7'd120;
    localparam logic [6:0] LLR_INF_RESET   = 7'd127;

    typedef enum logic {
        OP_ANALYZE = 1'b0,
        OP_EMIT    = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REG_LIFT_SIZE = 2'd0,
        REG_SCALE_Q7  = 2'd1,
        REG_LLR_MAX   = 2'd2,
        REG_LLR_INF   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [8:0] lift_size;
        logic [7:0] scale_q7;
        logic [6:0] llr_max;
        logic [6:0] llr_inf_code;
    } cfg_t;

    typedef struct packed {
        op_t               operation;
        logic              first_of_layer;
        logic [6:0]        var_index;
        logic [8:0]        position;
        logic [8:0]        rotation;
        logic signed [7:0] llr_a;
        logic signed [7:0] llr_b;
    } in_word_t;

    typedef struct packed {
        logic signed [7:0] llr_out;
        logic signed [7:0] soft_out;
    } out_word_t;

    // per-lane min-sum statistics held in the lane ram
    typedef struct packed {
        logic [6:0] min_mag;
        logic [6:0] second_mag;
        logic [6:0] min_owner;
        logic       sign_parity;
    } lane_stat_t;

endpackage

@@ rtl/ldpc_ram.sv @@
`timescale 1ns / 1ps

module ldpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port, read returns old data on collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/ldpc_cfg.sv @@
`timescale 1ns / 1ps

module ldpc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ldpc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [ldpc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ldpc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output ldpc_pkg::cfg_t                   cfg
);

    import ldpc_pkg::*;

    logic [8:0] lift_size_reg, lift_size_next;
    logic [7:0] scale_q7_reg, scale_q7_next;
    logic [6:0] llr_max_reg, llr_max_next;
    logic [6:0] llr_inf_reg, llr_inf_next;
    logic       wr_en;
    cfg_reg_t   reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = cfg_reg_t'(paddr[3:2]);

    // register write decode
    always_comb
    begin
        lift_size_next = lift_size_reg;
        scale_q7_next  = scale_q7_reg;
        llr_max_next   = llr_max_reg;
        llr_inf_next   = llr_inf_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_LIFT_SIZE: lift_size_next = pwdata[8:0];
                REG_SCALE_Q7:  scale_q7_next  = pwdata[7:0];
                REG_LLR_MAX:   llr_max_next   = pwdata[6:0];
                REG_LLR_INF:   llr_inf_next   = pwdata[6:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lift_size_reg <= LIFT_SIZE_RESET;
            scale_q7_reg  <= SCALE_RESET;
            llr_max_reg   <= LLR_MAX_RESET;
            llr_inf_reg   <= LLR_INF_RESET;
        end
        else
        begin
            lift_size_reg <= lift_size_next;
            scale_q7_reg  <= scale_q7_next;
            llr_max_reg   <= llr_max_next;
            llr_inf_reg   <= llr_inf_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_sel)
            REG_LIFT_SIZE: prdata = {{(APB_DATA_W-9){1'b0}}, lift_size_reg};
            REG_SCALE_Q7:  prdata = {{(APB_DATA_W-8){1'b0}}, scale_q7_reg};
            REG_LLR_MAX:   prdata = {{(APB_DATA_W-7){1'b0}}, llr_max_reg};
            REG_LLR_INF:   prdata = {{(APB_DATA_W-7){1'b0}}, llr_inf_reg};
        endcase
    end

    assign cfg.lift_size    = lift_size_reg;
    assign cfg.scale_q7     = scale_q7_reg;
    assign cfg.llr_max      = llr_max_reg;
    assign cfg.llr_inf_code = llr_inf_reg;

endmodule

@@ rtl/ldpc_lane_map.sv @@
`timescale 1ns / 1ps

module ldpc_lane_map #(
    parameter int MAX_LIFT = ldpc_pkg::LDPC_MAX_LIFT
) (
    input  logic                        clk,
    input  logic [8:0]                  lift_size,
    input  logic [8:0]                  position,
    input  logic [8:0]                  rotation,
    output logic [$clog2(MAX_LIFT)-1:0] lane
);

    localparam int LANE_W = $clog2(MAX_LIFT);

    logic [8:0] z;
    logic [8:0] pos_a_reg, rot_a_reg;
    logic [8:0] pos_b_reg, rot_b_reg;
    logic [9:0] lane_wide;

    // four restoring compare-subtract steps, quotient bits hi down to hi-3
    function automatic logic [8:0] mod_steps(input logic [8:0] rem_in,
                                             input logic [8:0] zv,
                                             input int hi);
        logic [8:0]  rem;
        logic [15:0] zs;
        rem = rem_in;
        for (int k = 0; k < 4; k++)
        begin
            zs = {7'b0, zv} << (hi - k);
            if ({7'b0, rem} >= zs)
            begin
                rem = rem - zs[8:0];
            end
        end
        return rem;
    endfunction

    // lifting size clamped to the lanes that exist
    always_comb
    begin
        priority if (lift_size < 9'd2)
            z = 9'd2;
        else if (lift_size > 9'(MAX_LIFT))
            z = 9'(MAX_LIFT);
        else
            z = lift_size;
    end

    // mod z over two stages, quotient fits in eight bits since z >= 2
    always_ff @(posedge clk)
    begin
        pos_a_reg <= mod_steps(position, z, 7);
        rot_a_reg <= mod_steps(rotation, z, 7);
        pos_b_reg <= mod_steps(pos_a_reg, z, 3);
        rot_b_reg <= mod_steps(rot_a_reg, z, 3);
    end

    // (p - r) mod z with both already reduced
    always_comb
    begin
        if (pos_b_reg >= rot_b_reg)
            lane_wide = {1'b0, pos_b_reg} - {1'b0, rot_b_reg};
        else
            lane_wide = {1'b0, pos_b_reg} + {1'b0, z} - {1'b0, rot_b_reg};
    end

    assign lane = lane_wide[LANE_W-1:0];

endmodule

@@ rtl/ldpc_out_fifo.sv @@
`timescale 1ns / 1ps

module ldpc_out_fifo #(
    parameter int DEPTH = ldpc_pkg::OUT_FIFO_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  ldpc_pkg::out_word_t        push_word,
    input  logic                       ready,
    output logic                       valid,
    output ldpc_pkg::out_word_t        word,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    import ldpc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    out_word_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign valid = (count_reg != '0);
    assign pop   = valid && ready;
    assign word  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

@@ rtl/ldpc_layered_min_sum_node.sv @@
// check-node unit: an accepted word moves through registers s1 to s4, then its result is pushed to the output queue
// throughput one word per cycle, set by the lane-state ram read-modify-write
// with one-deep write forwarding; no internal stall, backpressure by credit
// after reset a clearing pass over all MAX_LIFT lanes (384 by default) initializes
// the lane ram with in_ready low; configuration writes are taken meanwhile
`timescale 1ns / 1ps

module ldpc_layered_min_sum_node #(
    parameter int MAX_LIFT = ldpc_pkg::LDPC_MAX_LIFT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  ldpc_pkg::in_word_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ldpc_pkg::out_word_t             out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ldpc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ldpc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ldpc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    import ldpc_pkg::*;

`include "ldpc_layered_min_sum_node_assert.svh"

    localparam int LANE_W    = $clog2(MAX_LIFT);
    localparam int STAT_W    = $bits(lane_stat_t);
    localparam int OUT_DEPTH = OUT_FIFO_DEPTH;
    localparam int OCC_W     = $clog2(OUT_DEPTH+1);

    typedef struct packed {
        op_t               op;
        logic              first;
        logic [6:0]        var_index;
        logic signed [7:0] llr_a;
        logic signed [7:0] d;
        logic [6:0]        mag;
        logic              dneg;
    } stage_t;

    typedef struct packed {
        op_t               op;
        logic signed [7:0] llr_a;
        logic signed [7:0] d;
        logic [14:0]       prod;
        logic              cneg;
    } emit_t;

    cfg_t              cfg;
    logic              accept;

    // pipeline registers
    stage_t            s1_reg, s2_reg, s3_reg;
    emit_t             s4_reg, s4_next;
    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic [LANE_W-1:0] s3_lane_reg;

    // clearing pass
    logic              clearing_reg, clearing_next;
    logic [LANE_W-1:0] clr_addr_reg, clr_addr_next;

    // lane ram and forwarding
    logic [LANE_W-1:0] lane;
    logic              ram_we;
    logic [LANE_W-1:0] ram_waddr;
    logic [STAT_W-1:0] ram_wdata;
    logic [STAT_W-1:0] ram_rdata;
    lane_stat_t        rd_stat, cur_stat, base_stat, new_stat;
    logic              fwd_valid_reg, fwd_valid_next;
    logic [LANE_W-1:0] fwd_lane_reg;
    lane_stat_t        fwd_stat_reg;
    logic              fwd_hit;
    logic              item_wr;
    logic [6:0]        emit_mag;

    // analyze front end
    logic signed [9:0] a_ext, b_ext, diff, d_val;
    logic signed [9:0] mx_s, inf_s;
    stage_t            s1_next;

    // emit back end
    logic [7:0]        c0, c_mag;
    logic signed [9:0] c_s, fa_ext, sum, soft_val;
    logic              cpi, cmi, vpi, vmi;
    out_word_t         res_word;

    // output queue
    logic [OCC_W-1:0]  fifo_count;
    logic [OCC_W-1:0]  occ;

    ldpc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ldpc_lane_map #(
        .MAX_LIFT (MAX_LIFT)
    ) u_lane_map (
        .clk       (clk),
        .lift_size (cfg.lift_size),
        .position  (in_data.position),
        .rotation  (in_data.rotation),
        .lane      (lane)
    );

    ldpc_ram #(
        .WIDTH (STAT_W),
        .DEPTH (MAX_LIFT)
    ) u_lane_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (lane),
        .rdata (ram_rdata)
    );

    ldpc_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (v4_reg),
        .push_word (res_word),
        .ready     (out_ready),
        .valid     (out_valid),
        .word      (out_data),
        .count     (fifo_count)
    );

    // credit: every word in flight has a queue slot waiting for it
    assign occ = fifo_count + OCC_W'(v1_reg) + OCC_W'(v2_reg)
               + OCC_W'(v3_reg) + OCC_W'(v4_reg);
    assign in_ready = !clearing_reg && (occ < OCC_W'(OUT_DEPTH));
    assign accept   = in_valid && in_ready;

    assign mx_s  = {3'b000, cfg.llr_max};
    assign inf_s = {3'b000, cfg.llr_inf_code};

    // v2c = soft - c2v, saturated, clamped, with infinite soft bits forced
    always_comb
    begin
        a_ext = {{2{in_data.llr_a[7]}}, in_data.llr_a};
        b_ext = {{2{in_data.llr_b[7]}}, in_data.llr_b};
        diff  = a_ext - b_ext;
        d_val = diff;
        if (d_val > 10'sd127)
            d_val = 10'sd127;
        if (d_val < -10'sd128)
            d_val = -10'sd128;
        if (d_val > mx_s)
            d_val = mx_s;
        if (d_val < -mx_s)
            d_val = -mx_s;
        if (!(inf_s > a_ext))
            d_val = inf_s;
        if (!(a_ext > -inf_s))
            d_val = -inf_s;
        s1_next.op        = in_data.operation;
        s1_next.first     = in_data.first_of_layer;
        s1_next.var_index = in_data.var_index;
        s1_next.llr_a     = in_data.llr_a;
        s1_next.d         = d_val[7:0];
        s1_next.dneg      = d_val[9];
        s1_next.mag       = d_val[9] ? 7'(-d_val) : d_val[6:0];
    end

    // clearing pass sequencing
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            if (clr_addr_reg == LANE_W'(MAX_LIFT-1))
                clearing_next = 1'b0;
            else
                clr_addr_next = clr_addr_reg + 1'b1;
        end
    end

    // lane state read-modify-write
    assign rd_stat = lane_stat_t'(ram_rdata);
    assign fwd_hit = fwd_valid_reg && (fwd_lane_reg == s3_lane_reg);
    assign item_wr = v3_reg && (s3_reg.op == OP_ANALYZE);

    always_comb
    begin
        cur_stat = fwd_hit ? fwd_stat_reg : rd_stat;
        if (s3_reg.first)
        begin
            base_stat.min_mag     = cfg.llr_inf_code;
            base_stat.second_mag  = cfg.llr_inf_code;
            base_stat.min_owner   = 7'd0;
            base_stat.sign_parity = 1'b0;
        end
        else
        begin
            base_stat = cur_stat;
        end
        new_stat             = base_stat;
        new_stat.sign_parity = base_stat.sign_parity ^ s3_reg.dneg;
        if (base_stat.min_mag > s3_reg.mag)
        begin
            new_stat.min_mag   = s3_reg.mag;
            new_stat.min_owner = s3_reg.var_index;
            if (base_stat.second_mag > s3_reg.mag)
                new_stat.second_mag = base_stat.min_mag;
        end
        else if (base_stat.second_mag > s3_reg.mag)
        begin
            new_stat.second_mag = s3_reg.mag;
        end
    end

    // ram write port: clearing pass, then analyze updates
    always_comb
    begin
        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = {LLR_INF_RESET, LLR_INF_RESET, 7'd0, 1'b0};
        end
        else
        begin
            ram_we    = item_wr;
            ram_waddr = s3_lane_reg;
            ram_wdata = new_stat;
        end
    end

    assign fwd_valid_next = item_wr;

    // emit: pick the minimum over the other variable nodes and scale it
    always_comb
    begin
        emit_mag      = (s3_reg.var_index == cur_stat.min_owner) ? cur_stat.second_mag
                                                                 : cur_stat.min_mag;
        s4_next.op    = s3_reg.op;
        s4_next.llr_a = s3_reg.llr_a;
        s4_next.d     = s3_reg.d;
        s4_next.prod  = {8'b0, emit_mag} * {7'b0, cfg.scale_q7};
        s4_next.cneg  = s3_reg.llr_a[7] ^ cur_stat.sign_parity;
    end

    // emit: clamp, sign, and the new soft value with infinity rules; analyze words pass d
    always_comb
    begin
        c0       = s4_reg.prod[14:7];
        c_mag    = (c0 > {1'b0, cfg.llr_max}) ? {1'b0, cfg.llr_max} : c0;
        c_s      = s4_reg.cneg ? -$signed({2'b00, c_mag}) : $signed({2'b00, c_mag});
        fa_ext   = {{2{s4_reg.llr_a[7]}}, s4_reg.llr_a};
        cpi      = c_s > mx_s;
        cmi      = c_s < -mx_s;
        vpi      = fa_ext > mx_s;
        vmi      = fa_ext < -mx_s;
        sum      = c_s + fa_ext;
        soft_val = sum;
        if (soft_val > 10'sd127)
            soft_val = 10'sd127;
        if (soft_val < -10'sd128)
            soft_val = -10'sd128;
        if ((soft_val > mx_s) || (cpi && !vmi) || (vpi && !cmi))
            soft_val = inf_s;
        if ((soft_val < -mx_s) || (cmi && !vpi) || (vmi && !cpi))
            soft_val = -inf_s;
        if (s4_reg.op == OP_EMIT)
        begin
            res_word.llr_out  = c_s[7:0];
            res_word.soft_out = soft_val[7:0];
        end
        else
        begin
            res_word.llr_out  = s4_reg.d;
            res_word.soft_out = 8'sd0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            fwd_valid_reg <= 1'b0;
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
        end
        else
        begin
            v1_reg        <= accept;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            fwd_valid_reg <= fwd_valid_next;
            clearing_reg  <= clearing_next;
            clr_addr_reg  <= clr_addr_next;
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        s1_reg       <= s1_next;
        s2_reg       <= s1_reg;
        s3_reg       <= s2_reg;
        s3_lane_reg  <= lane;
        s4_reg       <= s4_next;
        fwd_lane_reg <= s3_lane_reg;
        fwd_stat_reg <= new_stat;
    end

    `LDPC_ASSERT_IMP(a_no_accept_clearing, clk, rst_n, clearing_reg, !in_ready, "accept in clear")
    `LDPC_ASSERT_IMP(a_clear_no_item, clk, rst_n, clearing_reg, !v3_reg, "item in clear")
    `LDPC_ASSERT_IMP(a_occ_bound, clk, rst_n, 1'b1, occ <= OCC_W'(OUT_DEPTH), "credit overrun")
    `LDPC_ASSERT_IMP(a_push_room, clk, rst_n, v4_reg, fifo_count < OCC_W'(OUT_DEPTH), "push when full")

endmodule

@@ tb/tb_ldpc_layered_min_sum_node.sv @@
`timescale 1ns / 1ps

module tb_ldpc_layered_min_sum_node;
    import ldpc_pkg::*;

    // per-lane min-sum prediction and the queue of words still owed by the block
    class check_node_scoreboard;
        logic [8:0] lift_size;
        logic [7:0] scale_q7;
        logic [6:0] llr_max;
        logic [6:0] llr_inf;
        logic [6:0] min_mag    [LDPC_MAX_LIFT];
        logic [6:0] second_mag [LDPC_MAX_LIFT];
        logic [6:0] min_owner  [LDPC_MAX_LIFT];
        bit         parity     [LDPC_MAX_LIFT];
        out_word_t  expected_words[$];
        int         words_checked;
        int         errors;

        function new();
            lift_size = LIFT_SIZE_RESET;
            scale_q7  = SCALE_RESET;
            llr_max   = LLR_MAX_RESET;
            llr_inf   = LLR_INF_RESET;
            for (int i = 0; i < LDPC_MAX_LIFT; i++)
            begin
                min_mag[i]    = LLR_INF_RESET;
                second_mag[i] = LLR_INF_RESET;
                min_owner[i]  = '0;
                parity[i]     = 1'b0;
            end
            words_checked = 0;
            errors        = 0;
        endfunction

        // returns the value a read of the register gives back
        function logic [31:0] set_reg(cfg_reg_t idx, logic [31:0] value);
            case (idx)
                REG_LIFT_SIZE:
                begin
                    lift_size = value[8:0];
                    return {23'd0, value[8:0]};
                end
                REG_SCALE_Q7:
                begin
                    scale_q7 = value[7:0];
                    return {24'd0, value[7:0]};
                end
                REG_LLR_MAX:
                begin
                    llr_max = value[6:0];
                    return {25'd0, value[6:0]};
                end
                default:
                begin
                    llr_inf = value[6:0];
                    return {25'd0, value[6:0]};
                end
            endcase
        endfunction

        // lifting size clamped to the lanes that exist
        function int lanes_in_use();
            int z;
            z = int'(lift_size);
            if (z < 2)
                z = 2;
            if (z > LDPC_MAX_LIFT)
                z = LDPC_MAX_LIFT;
            return z;
        endfunction

        function int sat8(int x);
            if (x > 127)
                return 127;
            if (x < -128)
                return -128;
            return x;
        endfunction

        // variable-to-check message with saturation and infinity rules
        function int v2c_of(logic signed [7:0] a, logic signed [7:0] b);
            int ai;
            int bi;
            int d;
            int mx;
            int inf;
            ai  = a;
            bi  = b;
            mx  = int'(llr_max);
            inf = int'(llr_inf);
            d   = sat8(ai - bi);
            if (d > mx)
                d = mx;
            if (d < -mx)
                d = -mx;
            if (ai >= inf)
                d = inf;
            if (ai <= -inf)
                d = -inf;
            return d;
        endfunction

        // accepted input word: update the lane on analyze and queue the owed result
        function void note_input(in_word_t w);
            int        z;
            int        lane;
            int        a;
            int        d;
            int        mag;
            int        m;
            int        c;
            int        s;
            int        mx;
            int        inf;
            bit        neg;
            bit        cpi;
            bit        cmi;
            bit        vpi;
            bit        vmi;
            out_word_t r;
            z    = lanes_in_use();
            lane = (int'(w.position) % z + z - int'(w.rotation) % z) % z;
            a    = $signed(w.llr_a);
            mx   = int'(llr_max);
            inf  = int'(llr_inf);
            if (w.operation == OP_ANALYZE)
            begin
                d   = v2c_of(w.llr_a, w.llr_b);
                mag = (d < 0 ? -d : d) & 127;
                if (w.first_of_layer)
                begin
                    min_mag[lane]    = llr_inf;
                    second_mag[lane] = llr_inf;
                    min_owner[lane]  = '0;
                    parity[lane]     = 1'b0;
                end
                parity[lane] = parity[lane] ^ (d < 0);
                if (int'(min_mag[lane]) > mag)
                begin
                    m               = min_mag[lane];
                    min_mag[lane]   = mag[6:0];
                    min_owner[lane] = w.var_index;
                end
                else
                    m = mag;
                if (int'(second_mag[lane]) > mag)
                    second_mag[lane] = m[6:0];
                r.llr_out  = d[7:0];
                r.soft_out = '0;
            end
            else
            begin
                m = (w.var_index == min_owner[lane]) ? int'(second_mag[lane])
                                                     : int'(min_mag[lane]);
                c = (m * int'(scale_q7)) >> 7;
                if (c > mx)
                    c = mx;
                neg = ((a < 0) != parity[lane]);
                if (neg)
                    c = -c;
                cpi = c > mx;
                cmi = c < -mx;
                vpi = a > mx;
                vmi = a < -mx;
                s   = sat8(c + a);
                if (s > mx || (cpi && !vmi) || (vpi && !cmi))
                    s = inf;
                if (s < -mx || (cmi && !vpi) || (vmi && !cpi))
                    s = -inf;
                r.llr_out  = c[7:0];
                r.soft_out = s[7:0];
            end
            expected_words.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // accepted output word against the oldest owed one
        task check_result(out_word_t got);
            out_word_t want;
            if (expected_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word llr_out=%0d soft_out=%0d",
                                          $signed(got.llr_out), $signed(got.soft_out)));
                return;
            end
            want = expected_words.pop_front();
            if (got.llr_out !== want.llr_out)
                report_mismatch($sformatf("word %0d llr_out got %0d want %0d", words_checked,
                                          $signed(got.llr_out), $signed(want.llr_out)));
            if (got.soft_out !== want.soft_out)
                report_mismatch($sformatf("word %0d soft_out got %0d want %0d", words_checked,
                                          $signed(got.soft_out), $signed(want.soft_out)));
            words_checked++;
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_word_t              in_data;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_word_t             out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    check_node_scoreboard sb = new();
    int send_idle;
    int recv_idle;
    int words_sent;

    ldpc_layered_min_sum_node i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watch both channels, then pick the next receiver stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
        end
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // llr values biased toward the saturation and infinity edges
    function automatic int rand_llr();
        int v;
        case ($urandom_range(0, 9))
            0:       v = 127;
            1:       v = -128;
            2:       v = int'(sb.llr_max) + int'($urandom_range(0, 2)) - 1;
            3:       v = int'(sb.llr_inf) + int'($urandom_range(0, 2)) - 1;
            4:       v = $urandom_range(0, 6);
            default: v = int'($urandom_range(0, 255)) - 128;
        endcase
        if ($urandom_range(0, 1))
            v = -v;
        if (v > 127)
            v = 127;
        if (v < -128)
            v = -128;
        return v;
    endfunction

    // one input word, with random idle cycles ahead of it
    task automatic send_item(op_t op, bit fresh, int vidx, int pos, int rot, int a, int b);
        in_word_t w;
        w.operation      = op;
        w.first_of_layer = fresh;
        w.var_index      = vidx[6:0];
        w.position       = pos[8:0];
        w.rotation       = rot[8:0];
        w.llr_a          = a[7:0];
        w.llr_b          = b[7:0];
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // register write then read back
    task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
        logic [31:0] want;
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        want = sb.set_reg(idx, value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        readback = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (readback !== want)
            sb.report_mismatch($sformatf("register %s read %0d want %0d",
                                         idx.name(), readback, want));
    endtask

    // wait until every owed word is back (or report those that never came), then let the pipeline settle
    task automatic drain();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (sb.expected_words.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.expected_words.size() != 0)
        begin
            sb.report_mismatch($sformatf("%0d words never came out",
                                         sb.expected_words.size()));
            sb.expected_words.delete();
        end
        repeat (8) @(posedge clk);
    endtask

    // mostly whole layers (analyze pass then emit pass) plus stray words
    task automatic send_random(int count);
        int target;
        int z;
        int n;
        int e_cnt;
        int base;
        int a;
        int b;
        int rot[6];
        int pos[6][3];
        int v2c[6][3];
        int lane[3];
        bit fresh;
        target = words_sent + count;
        z      = sb.lanes_in_use();
        while (words_sent < target)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_item(op_t'($urandom_range(0, 1)), $urandom_range(0, 1),
                          $urandom_range(0, 127), $urandom_range(0, 511),
                          $urandom_range(0, 511), rand_llr(), rand_llr());
            end
            else
            begin
                n     = $urandom_range(2, 6);
                e_cnt = $urandom_range(1, 3);
                base  = $urandom_range(0, 62);
                fresh = ($urandom_range(0, 9) != 0);
                for (int e = 0; e < e_cnt; e++)
                    lane[e] = $urandom_range(0, z - 1);
                // analyze pass
                for (int j = 0; j < n; j++)
                begin
                    rot[j] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                         : $urandom_range(0, z - 1);
                    for (int e = 0; e < e_cnt; e++)
                    begin
                        pos[j][e] = (lane[e] + rot[j]) % z;
                        pos[j][e] += z * $urandom_range(0, (511 - pos[j][e]) / z);
                        a = rand_llr();
                        b = rand_llr();
                        v2c[j][e] = sb.v2c_of(a[7:0], b[7:0]);
                        send_item(OP_ANALYZE, fresh && j == 0, base + j, pos[j][e], rot[j],
                                  a, b);
                    end
                end
                // emit pass, now and then a word dropped or a foreign v2c
                for (int j = 0; j < n; j++)
                begin
                    for (int e = 0; e < e_cnt; e++)
                    begin
                        if ($urandom_range(0, 9) != 0)
                        begin
                            a = ($urandom_range(0, 3) != 0) ? v2c[j][e] : rand_llr();
                            send_item(OP_EMIT, $urandom_range(0, 7) == 0, base + j,
                                      pos[j][e], rot[j], a, rand_llr());
                        end
                    end
                end
            end
        end
    endtask

    task automatic run_phase(int lift, int scale, int mx, int inf, int sidle, int ridle,
                             int count);
        drain();
        write_reg(REG_LIFT_SIZE, lift);
        write_reg(REG_SCALE_Q7, scale);
        write_reg(REG_LLR_MAX, mx);
        write_reg(REG_LLR_INF, inf);
        send_idle = sidle;
        recv_idle = ridle;
        send_random(count);
    endtask

    // main sequence
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        send_idle  = 13;
        recv_idle  = 58;
        words_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // lane 0 with reset settings: infinite, saturating and odd inputs
        send_item(OP_ANALYZE, 1, 0, 0, 0, 127, 0);
        send_item(OP_ANALYZE, 0, 1, 384, 0, -127, 5);
        send_item(OP_ANALYZE, 0, 2, 127, 511, -128, 127);
        send_item(OP_ANALYZE, 0, 3, 383, 383, 100, -100);
        send_item(OP_ANALYZE, 0, 67, 5, 5, 3, -128);
        send_item(OP_ANALYZE, 0, 127, 0, 0, -5, 3);
        send_item(OP_ANALYZE, 0, 4, 0, 0, 0, 0);
        send_item(OP_EMIT, 0, 0, 0, 0, 0, 0);
        send_item(OP_EMIT, 1, 4, 0, 0, -7, 0);
        send_item(OP_EMIT, 0, 127, 0, 0, 127, -128);
        send_item(OP_EMIT, 0, 1, 0, 0, -128, 127);
        send_item(OP_EMIT, 0, 3, 0, 0, 120, 0);
        send_item(OP_EMIT, 0, 2, 0, 0, -121, 0);
        send_item(OP_EMIT, 0, 50, 0, 0, 5, 0);
        // lane 383 reached by wrap-around, small magnitudes
        send_item(OP_ANALYZE, 1, 10, 0, 1, 2, 0);
        send_item(OP_ANALYZE, 0, 11, 382, 383, -1, 0);
        send_item(OP_ANALYZE, 0, 12, 511, 128, 0, 1);
        send_item(OP_EMIT, 0, 10, 0, 1, 2, 0);
        send_item(OP_EMIT, 0, 11, 382, 383, -1, 0);
        send_item(OP_EMIT, 0, 12, 511, 128, -1, 0);
        send_random(50);

        run_phase(2, 128, 1, 2, 13, 58, 55);
        run_phase(384, 0, 126, 127, 13, 58, 55);
        run_phase(1, 255, 60, 100, 58, 13, 55);
        run_phase(500, 64, 126, 90, 58, 13, 55);
        run_phase($urandom_range(2, 24), $urandom_range(0, 128), $urandom_range(1, 126),
                  $urandom_range(2, 127), 0, 0, 55);
        run_phase(7, 102, 100, 110, 0, 0, 55);
        drain();

        if (sb.errors == 0)
            $display("tb_ldpc_layered_min_sum_node OK");
        else
            $display("tb_ldpc_layered_min_sum_node NOT OK");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("tb_ldpc_layered_min_sum_node NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ldpc_pkg.sv
rtl/ldpc_ram.sv
rtl/ldpc_cfg.sv
rtl/ldpc_lane_map.sv
rtl/ldpc_out_fifo.sv
rtl/ldpc_layered_min_sum_node.sv
tb/tb_ldpc_layered_min_sum_node.sv
